>>> sv/xlsa_pkg.sv
package xlsa_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [CNT_WIDTH-1:0]  cnt_t;

	typedef enum logic [3:0] {
		CMD_AND   = 4'd0,
		CMD_OR    = 4'd1,
		CMD_XOR   = 4'd2,
		CMD_TEST  = 4'd3,
		CMD_NOT   = 4'd4,
		CMD_SHL   = 4'd5,
		CMD_SHR   = 4'd6,
		CMD_SAR   = 4'd7,
		CMD_ROL   = 4'd8,
		CMD_SETCC = 4'd9
	} cmd_t;

	localparam logic [1:0] WIDTH_8  = 2'd0;
	localparam logic [1:0] WIDTH_16 = 2'd1;

	typedef enum logic [2:0] {
		COND_O  = 3'd0,
		COND_B  = 3'd1,
		COND_E  = 3'd2,
		COND_BE = 3'd3,
		COND_S  = 3'd4,
		COND_P  = 3'd5,
		COND_L  = 3'd6,
		COND_LE = 3'd7
	} cond_t;

	typedef struct packed {
		logic cf;
		logic of;
		logic zf;
		logic sf;
		logic pf;
	} flags_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] width;
		data_t      dest;
		data_t      src;
		logic [3:0] cond;
		flags_t     flags;
	} item_t;

	typedef struct packed {
		data_t value;
		logic  we;
		logic  cf;
		logic  of;
		logic  zf;
		logic  sf;
	} result_t;

	function automatic data_t size_mask(input logic [1:0] width);
		data_t m;
		case (width)
			WIDTH_8:  m = data_t'(8'hff);
			WIDTH_16: m = data_t'(16'hffff);
			default:  m = '1;
		endcase
		return m;
	endfunction

	function automatic logic msb(input data_t v, input logic [1:0] width);
		logic b;
		case (width)
			WIDTH_8:  b = v[7];
			WIDTH_16: b = v[15];
			default:  b = v[DATA_WIDTH-1];
		endcase
		return b;
	endfunction

endpackage

>>> sv/x86_logic_shift_alu_core.sv
// channel  handshake            payload
// input    in_valid / in_ready   cmd, operand_width, dest_value, src_value, cond_code,
//                                cf_in, of_in, zf_in, sf_in, pf_in
// output   out_valid / out_ready result_value, write_enable, cf_out, of_out, zf_out, sf_out
//
// One item per cycle while the output is not stalled; an accepted item is registered
// first in the input register and then in the result register, from which it is offered.
// The logic between them is a single pass of logic ops, a barrel shifter and flag decode.
// arst_n clears both valid bits; payload registers are not reset.
// A stalled output holds the result register and the input register fills behind it.
module x86_logic_shift_alu_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [3:0]                         cmd,
	input  logic [1:0]                         operand_width,
	input  logic [xlsa_pkg::DATA_WIDTH-1:0]    dest_value,
	input  logic [xlsa_pkg::DATA_WIDTH-1:0]    src_value,
	input  logic [3:0]                         cond_code,
	input  logic                               cf_in,
	input  logic                               of_in,
	input  logic                               zf_in,
	input  logic                               sf_in,
	input  logic                               pf_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [xlsa_pkg::DATA_WIDTH-1:0]    result_value,
	output logic                               write_enable,
	output logic                               cf_out,
	output logic                               of_out,
	output logic                               zf_out,
	output logic                               sf_out
);

	xlsa_pkg::item_t   item_s1;
	logic              v_s1;
	xlsa_pkg::result_t res_s2;
	logic              v_s2;
	xlsa_pkg::result_t res_c;
	logic              adv;

	assign adv      = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd      <= xlsa_pkg::cmd_t'(cmd);
			item_s1.width    <= operand_width;
			item_s1.dest     <= dest_value;
			item_s1.src      <= src_value;
			item_s1.cond     <= cond_code;
			item_s1.flags.cf <= cf_in;
			item_s1.flags.of <= of_in;
			item_s1.flags.zf <= zf_in;
			item_s1.flags.sf <= sf_in;
			item_s1.flags.pf <= pf_in;
		end
		if (adv && v_s1) begin
			res_s2 <= res_c;
		end
	end

	xlsa_exec u_exec (
		.item   (item_s1),
		.result (res_c)
	);

	assign out_valid    = v_s2;
	assign result_value = res_s2.value;
	assign write_enable = res_s2.we;
	assign cf_out       = res_s2.cf;
	assign of_out       = res_s2.of;
	assign zf_out       = res_s2.zf;
	assign sf_out       = res_s2.sf;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item did not reach input register");

	a_s1_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> out_valid)
		else $error("item in input register did not reach result register");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(item_s1)))
		else $error("input register changed during output stall");

	a_ready_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> (in_ready == !v_s1))
		else $error("in_ready wrong while output stalled");
`endif

endmodule

>>> sv/xlsa_shift.sv
module xlsa_shift (
	input  xlsa_pkg::cmd_t  cmd,
	input  logic [1:0]      width,
	input  xlsa_pkg::data_t d,
	input  xlsa_pkg::cnt_t  cnt,
	output xlsa_pkg::data_t value
);

	xlsa_pkg::data_t                     rep;
	xlsa_pkg::data_t                     sext;
	logic [2*xlsa_pkg::DATA_WIDTH-1:0]   dbl;

	always_comb begin
		case (width)
			xlsa_pkg::WIDTH_8: begin
				rep  = {4{d[7:0]}};
				sext = {{24{d[7]}}, d[7:0]};
			end
			xlsa_pkg::WIDTH_16: begin
				rep  = {2{d[15:0]}};
				sext = {{16{d[15]}}, d[15:0]};
			end
			default: begin
				rep  = d;
				sext = d;
			end
		endcase
		dbl = {rep, rep} << cnt;
	end

	always_comb begin
		case (cmd)
			xlsa_pkg::CMD_SHL: value = d << cnt;
			xlsa_pkg::CMD_SHR: value = d >> cnt;
			xlsa_pkg::CMD_SAR: value = xlsa_pkg::data_t'($signed(sext) >>> cnt);
			xlsa_pkg::CMD_ROL: value = dbl[2*xlsa_pkg::DATA_WIDTH-1:xlsa_pkg::DATA_WIDTH];
			default:           value = '0;
		endcase
	end

endmodule

>>> sv/xlsa_exec.sv
module xlsa_exec (
	input  xlsa_pkg::item_t   item,
	output xlsa_pkg::result_t result
);

	xlsa_pkg::data_t mask;
	xlsa_pkg::data_t d;
	xlsa_pkg::data_t s;
	xlsa_pkg::cnt_t  cnt;
	xlsa_pkg::data_t shift_value;
	xlsa_pkg::data_t res;
	xlsa_pkg::data_t res_m;
	xlsa_pkg::flags_t f;
	logic            cond_hit;
	logic            we;
	logic            cf;
	logic            of;
	logic            logic_op;
	logic            zs_op;

	assign mask = xlsa_pkg::size_mask(item.width);
	assign d    = item.dest & mask;
	assign s    = item.src;
	assign cnt  = s[xlsa_pkg::CNT_WIDTH-1:0];
	assign f    = item.flags;

	xlsa_shift u_shift (
		.cmd   (item.cmd),
		.width (item.width),
		.d     (d),
		.cnt   (cnt),
		.value (shift_value)
	);

	always_comb begin
		unique case (xlsa_pkg::cond_t'(item.cond[3:1]))
			xlsa_pkg::COND_O:  cond_hit = f.of;
			xlsa_pkg::COND_B:  cond_hit = f.cf;
			xlsa_pkg::COND_E:  cond_hit = f.zf;
			xlsa_pkg::COND_BE: cond_hit = f.cf | f.zf;
			xlsa_pkg::COND_S:  cond_hit = f.sf;
			xlsa_pkg::COND_P:  cond_hit = f.pf;
			xlsa_pkg::COND_L:  cond_hit = f.sf ^ f.of;
			xlsa_pkg::COND_LE: cond_hit = f.zf | (f.sf ^ f.of);
		endcase
		cond_hit = cond_hit ^ item.cond[0];
	end

	always_comb begin
		res      = '0;
		we       = 1'b0;
		cf       = f.cf;
		of       = f.of;
		logic_op = 1'b0;
		zs_op    = 1'b0;
		unique case (item.cmd) inside
			xlsa_pkg::CMD_AND: begin
				res      = d & s;
				we       = 1'b1;
				logic_op = 1'b1;
			end
			xlsa_pkg::CMD_OR: begin
				res      = d | s;
				we       = 1'b1;
				logic_op = 1'b1;
			end
			xlsa_pkg::CMD_XOR: begin
				res      = d ^ s;
				we       = 1'b1;
				logic_op = 1'b1;
			end
			xlsa_pkg::CMD_TEST: begin
				res      = d & s;
				logic_op = 1'b1;
			end
			xlsa_pkg::CMD_NOT: begin
				res = ~d;
				we  = 1'b1;
			end
			xlsa_pkg::CMD_SHL, xlsa_pkg::CMD_SHR, xlsa_pkg::CMD_SAR: begin
				res   = shift_value;
				we    = 1'b1;
				zs_op = 1'b1;
			end
			xlsa_pkg::CMD_ROL: begin
				res = shift_value & mask;
				we  = 1'b1;
				if (cnt != '0) begin
					cf = res[0];
				end
				if (cnt == xlsa_pkg::cnt_t'(1)) begin
					of = xlsa_pkg::msb(res, item.width) ^ res[0];
				end
			end
			xlsa_pkg::CMD_SETCC: begin
				res = xlsa_pkg::data_t'(cond_hit);
				we  = 1'b1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	assign res_m = res & mask;

	always_comb begin
		result.value = res_m;
		result.we    = we;
		result.cf    = logic_op ? 1'b0 : cf;
		result.of    = logic_op ? 1'b0 : of;
		result.zf    = (logic_op || zs_op) ? (res_m == '0) : f.zf;
		result.sf    = (logic_op || zs_op) ? xlsa_pkg::msb(res_m, item.width) : f.sf;
	end

endmodule
